>>> sv/sos_pkg.sv
// ----------------------------------------------------------------------------
// sos_pkg
// Types, register codes, reset values and sine polynomial constants shared by
// the sine oscillator with sweep.
// ----------------------------------------------------------------------------
package sos_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int SAMPLE_W   = 16;
	localparam int INC_W      = 32;
	localparam int AMP_W      = 16;
	localparam int SCALE_FRAC = 30;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [INC_W-1:0]           inc_t;
	typedef logic [AMP_W-1:0]           amp_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_INC   = 3'd0,
		CFG_AMPLITUDE   = 3'd1,
		CFG_SWEEP_EN    = 3'd2,
		CFG_INC_LOW     = 3'd3,
		CFG_INC_HIGH    = 3'd4,
		CFG_UP_SCALER   = 3'd5,
		CFG_DOWN_SCALER = 3'd6
	} cfg_reg_t;

	localparam inc_t RST_START_INC = 32'd39370534;
	localparam amp_t RST_AMPLITUDE = 16'd328;
	localparam inc_t RST_INC_LOW   = 32'd0;
	localparam inc_t RST_INC_HIGH  = 32'hFFFF_FFFF;
	localparam inc_t UNITY_SCALER  = 32'd1073741824;

	localparam logic [16:0] X_ONE    = 17'd65536;
	localparam logic [16:0] POLY_A   = 17'd102944;
	localparam logic [15:0] POLY_B   = 16'd42047;
	localparam logic [12:0] POLY_C   = 13'd4640;
	localparam logic [14:0] MAG_MAX  = 15'd32767;

	localparam sample_t SAMPLE_MAX = 16'sh7FFF;
	localparam sample_t SAMPLE_MIN = 16'sh8000;

endpackage

>>> sv/sos_if.sv
// ----------------------------------------------------------------------------
// sos_if
// Valid/ready channels of the sine oscillator: sample in, sample out and
// register writes.
// ----------------------------------------------------------------------------
interface sos_in_if;
	import sos_pkg::*;
	logic    valid;
	logic    ready;
	sample_t mix_in;
	modport source (output valid, output mix_in, input ready);
	modport sink (input valid, input mix_in, output ready);
endinterface

interface sos_out_if;
	import sos_pkg::*;
	logic    valid;
	logic    ready;
	sample_t mix_out;
	modport source (output valid, output mix_out, input ready);
	modport sink (input valid, input mix_out, output ready);
endinterface

interface sos_cfg_if;
	import sos_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/sos_ctrl.sv
// ----------------------------------------------------------------------------
// sos_ctrl
// Register file, phase accumulator and ping-pong increment sweep.
// ----------------------------------------------------------------------------
module sos_ctrl #(
	parameter int unsigned PHASE_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	sos_cfg_if.sink                 cfg,
	input  logic                    step,
	output logic [PHASE_BITS-1:0]   phase,
	output sos_pkg::amp_t           amplitude
);
	import sos_pkg::*;

	amp_t                  amp_q;
	logic                  sweep_en_q;
	inc_t                  inc_low_q;
	inc_t                  inc_high_q;
	inc_t                  up_scl_q;
	inc_t                  dn_scl_q;
	logic [PHASE_BITS-1:0] phase_q;
	inc_t                  inc_q;
	logic                  sweep_up_q;

	logic                  cfg_we;
	cfg_reg_t              cfg_sel;
	inc_t                  scl;
	logic [2*INC_W-1:0]    prod;
	logic [INC_W+1:0]      prod_sh;
	inc_t                  inc_scaled;
	logic                  turn_dn;
	logic                  turn_up;
	logic [PHASE_BITS-1:0] phase_nxt;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;
	assign cfg_sel   = cfg_reg_t'(cfg.index);

	assign scl        = sweep_up_q ? up_scl_q : dn_scl_q;
	assign prod       = (2*INC_W)'(inc_q) * (2*INC_W)'(scl);
	assign prod_sh    = prod[2*INC_W-1:SCALE_FRAC];
	assign inc_scaled = (|prod_sh[INC_W+1:INC_W]) ? '1 : prod_sh[INC_W-1:0];
	assign turn_dn    = inc_scaled > inc_high_q;
	assign turn_up    = inc_scaled < inc_low_q;
	assign phase_nxt  = phase_q + PHASE_BITS'(inc_q);

	assign phase     = phase_q;
	assign amplitude = amp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q      <= RST_AMPLITUDE;
			sweep_en_q <= 1'b0;
			inc_low_q  <= RST_INC_LOW;
			inc_high_q <= RST_INC_HIGH;
			up_scl_q   <= UNITY_SCALER;
			dn_scl_q   <= UNITY_SCALER;
			phase_q    <= '0;
			inc_q      <= RST_START_INC;
			sweep_up_q <= 1'b1;
		end else begin
			if (step) begin
				phase_q <= phase_nxt;
			end
			if (step && sweep_en_q) begin
				inc_q <= inc_scaled;
				if (sweep_up_q && turn_dn) begin
					sweep_up_q <= 1'b0;
				end else if (!sweep_up_q && turn_up) begin
					sweep_up_q <= 1'b1;
				end
			end
			if (cfg_we) begin
				case (cfg_sel)
					CFG_START_INC: begin
						inc_q <= cfg.data;
					end
					CFG_AMPLITUDE: begin
						amp_q <= cfg.data[AMP_W-1:0];
					end
					CFG_SWEEP_EN: begin
						sweep_en_q <= cfg.data[0];
						if (cfg.data[0]) begin
							sweep_up_q <= 1'b1;
						end
					end
					CFG_INC_LOW: begin
						inc_low_q <= cfg.data;
					end
					CFG_INC_HIGH: begin
						inc_high_q <= cfg.data;
					end
					CFG_UP_SCALER: begin
						up_scl_q <= cfg.data;
					end
					CFG_DOWN_SCALER: begin
						dn_scl_q <= cfg.data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> phase_q == $past(phase_nxt))
		else $error("phase did not advance by the increment");

	a_inc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!sweep_en_q && !(cfg_we && cfg_sel == CFG_START_INC)) |=> inc_q == $past(inc_q))
		else $error("increment moved with sweep off");

	a_no_rise: assert property (@(posedge clk) disable iff (!arst_n)
		(step && sweep_en_q && sweep_up_q && up_scl_q <= UNITY_SCALER && !cfg_we)
		|=> inc_q <= $past(inc_q))
		else $error("increment grew with scaler at or below one");

endmodule

>>> sv/sos_tone.sv
// ----------------------------------------------------------------------------
// sos_tone
// Seven-stage sine pipeline: polynomial sine of the phase, gain, and
// saturating mix into the incoming sample. At most one multiply per stage.
// ----------------------------------------------------------------------------
module sos_tone #(
	parameter int unsigned PHASE_BITS      = 32,
	parameter int unsigned SINE_TABLE_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sos_in_if.sink                in_ch,
	sos_out_if.source             out_ch,
	input  logic [PHASE_BITS-1:0] phase,
	input  sos_pkg::amp_t         amplitude
);
	import sos_pkg::*;

	localparam int unsigned R_BITS  = SINE_TABLE_BITS - 2;
	localparam int unsigned X_SHIFT = 16 - R_BITS;

	logic [1:0]        quad;
	logic [R_BITS-1:0] r;
	logic [16:0]       x_raw;
	logic [16:0]       x_in;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7;

	sample_t     mix_s1, mix_s2, mix_s3, mix_s4, mix_s5, mix_s6;
	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [16:0] x_s1, x_s2, x_s3, x_s4;
	logic [16:0] x2_s2, x2_s3;
	logic [15:0] p1_s3;
	logic [16:0] p2_s4;
	logic [16:0] p3_s5;
	logic [14:0] m_s6;
	sample_t     sum_s7;

	logic [33:0] prod_xx;
	logic [29:0] prod_c;
	logic [32:0] prod_p1;
	logic [33:0] prod_p2;
	logic [31:0] prod_m;
	logic [30:0] prod_a;
	logic [15:0] p1_nxt;
	logic [16:0] p2_nxt;
	logic [15:0] m_raw;
	logic [14:0] m_nxt;
	logic [15:0] tone_mag;
	logic [17:0] tone_ext;
	logic [17:0] tone_sgn;
	logic [17:0] sum_w;
	sample_t     sum_sat;

	assign quad  = phase[PHASE_BITS-1 -: 2];
	assign r     = phase[PHASE_BITS-3 -: R_BITS];
	assign x_raw = 17'(r) << X_SHIFT;
	assign x_in  = quad[0] ? (X_ONE - x_raw) : x_raw;

	assign rdy_s7 = !v_s7 || out_ch.ready;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign in_ch.ready    = rdy_s1;
	assign out_ch.valid   = v_s7;
	assign out_ch.mix_out = sum_s7;

	assign prod_xx = 34'(x_s1) * 34'(x_s1);
	assign prod_c  = 30'(x2_s2) * 30'(POLY_C);
	assign p1_nxt  = POLY_B - 16'(prod_c[29:16]);
	assign prod_p1 = 33'(x2_s3) * 33'(p1_s3);
	assign p2_nxt  = POLY_A - prod_p1[32:16];
	assign prod_p2 = 34'(x_s4) * 34'(p2_s4);
	assign prod_m  = 32'(p3_s5) * 32'(MAG_MAX);
	assign m_raw   = prod_m[31:16];
	assign m_nxt   = (m_raw > 16'(MAG_MAX)) ? MAG_MAX : m_raw[14:0];

	assign prod_a   = 31'(m_s6) * 31'(amplitude);
	assign tone_mag = prod_a[30:15];
	assign tone_ext = {2'b00, tone_mag};
	assign tone_sgn = neg_s6 ? (18'd0 - tone_ext) : tone_ext;
	assign sum_w    = {{2{mix_s6[SAMPLE_W-1]}}, mix_s6} + tone_sgn;

	always_comb begin
		if ($signed(sum_w) > 18'sd32767) begin
			sum_sat = SAMPLE_MAX;
		end else if ($signed(sum_w) < -18'sd32768) begin
			sum_sat = SAMPLE_MIN;
		end else begin
			sum_sat = sum_w[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_ch.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_ch.valid) begin
			mix_s1 <= in_ch.mix_in;
			neg_s1 <= quad[1];
			x_s1   <= x_in;
		end
		if (rdy_s2 && v_s1) begin
			mix_s2 <= mix_s1;
			neg_s2 <= neg_s1;
			x_s2   <= x_s1;
			x2_s2  <= prod_xx[32:16];
		end
		if (rdy_s3 && v_s2) begin
			mix_s3 <= mix_s2;
			neg_s3 <= neg_s2;
			x_s3   <= x_s2;
			x2_s3  <= x2_s2;
			p1_s3  <= p1_nxt;
		end
		if (rdy_s4 && v_s3) begin
			mix_s4 <= mix_s3;
			neg_s4 <= neg_s3;
			x_s4   <= x_s3;
			p2_s4  <= p2_nxt;
		end
		if (rdy_s5 && v_s4) begin
			mix_s5 <= mix_s4;
			neg_s5 <= neg_s4;
			p3_s5  <= prod_p2[32:16];
		end
		if (rdy_s6 && v_s5) begin
			mix_s6 <= mix_s5;
			neg_s6 <= neg_s5;
			m_s6   <= m_nxt;
		end
		if (rdy_s7 && v_s6) begin
			sum_s7 <= sum_sat;
		end
	end

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> v_s1)
		else $error("accepted word missing from first stage");

	a_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s7 |-> in_ch.ready)
		else $error("empty output stage but input stalled");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy_s2) |=> (v_s1 && $stable(mix_s1) && $stable(x_s1)))
		else $error("first stage lost a stalled word");

endmodule

>>> sv/sine_oscillator_with_sweep.sv
// ----------------------------------------------------------------------------
// sine_oscillator_with_sweep
// Oscillator that mixes a scaled sine tone into a 16-bit sample stream, with
// an optional ping-pong exponential sweep of the phase increment.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one signed 16-bit word per accepted transfer (valid & ready).
//   out_ch : one signed 16-bit word per input word, same order, saturated.
//   cfg    : register writes by index; always ready. Write only while no
//            word is in flight.
// Pipeline: an accepted word is registered in stages s1 to s7; out_ch.valid is the s7 valid.
// Throughput: one word per clock while out_ch.ready does not stall; the
//   seven-stage sine pipeline and the phase/increment update set this figure.
// Each stage holds its word while the next one is full, so bubbles close up
//   and input is taken while a result waits on out_ch. With all seven stages
//   full and out_ch.ready low, in_ch.ready drops.
// Reset: pipeline empties, phase clears, increment loads its reset start
//   value, sweep off and pointing upward, registers to their reset values.
// ----------------------------------------------------------------------------
module sine_oscillator_with_sweep #(
	parameter int unsigned PHASE_BITS      = 32,
	parameter int unsigned SINE_TABLE_BITS = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	sos_in_if.sink    in_ch,
	sos_out_if.source out_ch,
	sos_cfg_if.sink   cfg
);
	import sos_pkg::*;

	logic [PHASE_BITS-1:0] phase;
	amp_t                  amplitude;
	logic                  in_fire;

	assign in_fire = in_ch.valid && in_ch.ready;

	sos_ctrl #(
		.PHASE_BITS (PHASE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (in_fire),
		.phase     (phase),
		.amplitude (amplitude)
	);

	sos_tone #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_tone (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.phase     (phase),
		.amplitude (amplitude)
	);

endmodule

>>> verif/tb_sine_oscillator_with_sweep.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sine_oscillator_with_sweep
// Drives sample words through the oscillator under changing register settings
// and random stalls on both sides. An in-bench oscillator model predicts each
// mixed sample; every output word is checked in order against it.
// ----------------------------------------------------------------------------
module tb_sine_oscillator_with_sweep;
	import sos_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int PH_W       = 32;
	localparam int TBL_W      = 10;
	localparam int LONG_STALL = 300;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE     = 20;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	logic clk = 1'b0;
	logic arst_n;

	sos_in_if  in_if ();
	sos_out_if out_if ();
	sos_cfg_if cfg_if ();

	sine_oscillator_with_sweep #(
		.PHASE_BITS      (PH_W),
		.SINE_TABLE_BITS (TBL_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if),
		.cfg    (cfg_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// oscillator model state and registers
	logic [PH_W-1:0] osc_phase    = '0;
	inc_t            osc_inc      = RST_START_INC;
	logic            osc_up       = 1'b1;
	amp_t            osc_amp      = RST_AMPLITUDE;
	logic            osc_sweep    = 1'b0;
	inc_t            osc_inc_low  = RST_INC_LOW;
	inc_t            osc_inc_high = RST_INC_HIGH;
	inc_t            osc_up_scale = UNITY_SCALER;
	inc_t            osc_dn_scale = UNITY_SCALER;

	sample_t mix_expect_q[$];
	sample_t want;
	int      err_count   = 0;
	int      tx_idle_pct = 0;
	int      rx_idle_pct = 0;
	bit      stall_req   = 1'b0;
	bit      stall_seen  = 1'b0;
	int      stall_left  = 0;
	int      idle_run    = 0;

	function automatic inc_t scaled_increment(input inc_t v, input inc_t f);
		longint unsigned prod;
		prod = (64'(v) * 64'(f)) >> SCALE_FRAC;
		if (prod > 64'hFFFF_FFFF)
			return '1;
		return inc_t'(prod);
	endfunction

	function automatic sample_t mix_and_advance(input sample_t s);
		longint unsigned k, quad, x, x2, p, m;
		int tone, sum;
		k = osc_phase >> (PH_W - TBL_W);
		quad = (k >> (TBL_W - 2)) & 3;
		x = (k & ((64'd1 << (TBL_W - 2)) - 1)) << (16 - (TBL_W - 2));
		if (quad[0])
			x = X_ONE - x;
		x2 = (x * x) >> 16;
		p = POLY_B - ((x2 * POLY_C) >> 16);
		p = POLY_A - ((x2 * p) >> 16);
		p = (x * p) >> 16;
		m = (p * MAG_MAX) >> 16;
		if (m > MAG_MAX)
			m = MAG_MAX;
		tone = int'((m * osc_amp) >> 15);
		if (quad >= 2)
			tone = -tone;
		sum = int'(s) + tone;
		if (sum > int'(SAMPLE_MAX))
			sum = int'(SAMPLE_MAX);
		if (sum < int'(SAMPLE_MIN))
			sum = int'(SAMPLE_MIN);
		osc_phase = osc_phase + osc_inc;
		if (osc_sweep) begin
			if (osc_up) begin
				osc_inc = scaled_increment(osc_inc, osc_up_scale);
				if (osc_inc > osc_inc_high)
					osc_up = 1'b0;
			end else begin
				osc_inc = scaled_increment(osc_inc, osc_dn_scale);
				if (osc_inc < osc_inc_low)
					osc_up = 1'b1;
			end
		end
		return sample_t'(sum);
	endfunction

	function automatic sample_t random_sample();
		case ($urandom_range(19))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return '0;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic bit pick(input bit forced);
		return forced || ($urandom_range(4) != 0);
	endfunction

	task automatic set_idle(input int tx, input int rx);
		tx_idle_pct = tx;
		rx_idle_pct <= rx;
	endtask

	task automatic send_sample(input sample_t s);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid  <= 1'b1;
		in_if.mix_in <= s;
		do @(posedge clk); while (!in_if.ready);
		mix_expect_q.push_back(mix_and_advance(s));
	endtask

	task automatic drain();
		in_if.valid <= 1'b0;
		do @(posedge clk); while (mix_expect_q.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		case (idx)
			CFG_START_INC:   osc_inc = val;
			CFG_AMPLITUDE:   osc_amp = val[AMP_W-1:0];
			CFG_SWEEP_EN: begin
				osc_sweep = val[0];
				if (val[0])
					osc_up = 1'b1;
			end
			CFG_INC_LOW:     osc_inc_low  = val;
			CFG_INC_HIGH:    osc_inc_high = val;
			CFG_UP_SCALER:   osc_up_scale = val;
			CFG_DOWN_SCALER: osc_dn_scale = val;
			default: ;
		endcase
	endtask

	task automatic test_reset_values();
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample('0);
		send_sample(sample_t'(-1));
		drain();
	endtask

	task automatic test_full_scale_tone();
		write_reg(CFG_AMPLITUDE, 32'h0000_8000);
		write_reg(CFG_START_INC, 32'h2000_0000);
		for (int i = 0; i < 8; i++)
			send_sample(i[0] ? SAMPLE_MIN : SAMPLE_MAX);
		// gain above unity, upper data bits dropped
		write_reg(CFG_AMPLITUDE, 32'hFFFF_FFFF);
		for (int i = 0; i < 3; i++)
			send_sample('0);
		write_reg(CFG_AMPLITUDE, 32'h0001_0000);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		drain();
	endtask

	task automatic test_sweep_corners();
		write_reg(CFG_AMPLITUDE, 32'h0000_8000);
		write_reg(CFG_START_INC, 32'hC000_0001);
		write_reg(CFG_UP_SCALER, 32'hFFFF_FFFF);
		write_reg(CFG_SWEEP_EN, 32'h0000_0001);
		send_sample(random_sample());
		send_sample(random_sample());
		write_reg(CFG_INC_HIGH, 32'h8000_0000);
		write_reg(CFG_DOWN_SCALER, 32'h2000_0001);
		for (int i = 0; i < 3; i++)
			send_sample(random_sample());
		write_reg(CFG_START_INC, 32'h0000_0000);
		send_sample(random_sample());
		send_sample(random_sample());
		// bounds crossed over: turn on every step
		write_reg(CFG_INC_LOW, 32'hF000_0000);
		write_reg(CFG_INC_HIGH, 32'h1000_0000);
		write_reg(CFG_UP_SCALER, UNITY_SCALER);
		write_reg(CFG_DOWN_SCALER, UNITY_SCALER);
		write_reg(CFG_START_INC, 32'h2000_0000);
		write_reg(CFG_SWEEP_EN, 32'h0000_0001);
		for (int i = 0; i < 3; i++)
			send_sample(random_sample());
		write_reg(CFG_SWEEP_EN, 32'hFFFF_FFFE);
		send_sample(random_sample());
		send_sample(random_sample());
		write_reg(CFG_SPARE, $urandom);
		send_sample(random_sample());
		drain();
	endtask

	task automatic test_input_stall();
		stall_req <= ~stall_req;
		for (int i = 0; i < 60; i++)
			send_sample(random_sample());
		drain();
	endtask

	task automatic test_random_settings(input int tx, input int rx, input int n_items);
		int              sent;
		int              burst;
		bit              shaped;
		inc_t            base, lo, up_f, dn_f;
		longint unsigned hi;
		amp_t            amp;
		set_idle(tx, rx);
		sent = 0;
		while (sent < n_items) begin
			shaped = ($urandom_range(9) < 7);
			case ($urandom_range(3))
				0: base = $urandom;
				1: base = $urandom_range(32'h0001_0000, 32'h0400_0000);
				2: base = $urandom_range(32'h0400_0000, 32'h4000_0000);
				default: base = $urandom_range(1) ? '1 : '0;
			endcase
			if (shaped) begin
				lo = base >> $urandom_range(1, 3);
				hi = 64'(base) + 64'(base >> $urandom_range(0, 2));
				if (hi > 64'hFFFF_FFFF)
					hi = 64'hFFFF_FFFF;
				up_f = UNITY_SCALER + $urandom_range(0, 32'h0200_0000);
				dn_f = UNITY_SCALER - $urandom_range(0, 32'h0200_0000);
			end else begin
				lo = $urandom;
				hi = $urandom;
				up_f = ($urandom_range(2) == 0) ? '1 : $urandom;
				dn_f = ($urandom_range(2) == 0) ? '0 : $urandom;
			end
			case ($urandom_range(4))
				0: amp = '0;
				1: amp = 16'h8000;
				2: amp = '1;
				default: amp = $urandom_range(0, 32768);
			endcase
			if (pick(shaped))
				write_reg(CFG_START_INC, base);
			if (pick(1'b0))
				write_reg(CFG_AMPLITUDE, {16'($urandom), amp});
			if (pick(shaped))
				write_reg(CFG_SWEEP_EN, {31'($urandom), shaped ? 1'b1 : 1'($urandom)});
			if (pick(shaped))
				write_reg(CFG_INC_LOW, lo);
			if (pick(shaped))
				write_reg(CFG_INC_HIGH, hi[31:0]);
			if (pick(shaped))
				write_reg(CFG_UP_SCALER, up_f);
			if (pick(shaped))
				write_reg(CFG_DOWN_SCALER, dn_f);
			if ($urandom_range(9) == 0)
				write_reg(CFG_SPARE, $urandom);
			burst = $urandom_range(15, 70);
			repeat (burst)
				send_sample(random_sample());
			sent += burst;
			drain();
		end
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_if.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if (stall_req != stall_seen) begin
			stall_seen   <= stall_req;
			stall_left   <= LONG_STALL;
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready) begin
			if (mix_expect_q.size() == 0) begin
				$error("mix_out: unexpected word %0d", out_if.mix_out);
				err_count++;
			end else begin
				want = mix_expect_q.pop_front();
				if (out_if.mix_out !== want) begin
					$error("mix_out mismatch: expected %0d, actual %0d", want, out_if.mix_out);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
			idle_run <= 0;
		end else if (idle_run >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_if.valid  = 1'b0;
		in_if.mix_in = '0;
		out_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idle(7, 55);
		test_reset_values();
		test_full_scale_tone();
		test_sweep_corners();
		test_input_stall();
		test_random_settings(7, 55, 530);
		test_random_settings(55, 7, 530);
		test_random_settings(0, 0, 530);
		drain();
		repeat (SETTLE) @(posedge clk);
		if (mix_expect_q.size() != 0) begin
			$error("mix_out: %0d expected words never arrived", mix_expect_q.size());
			err_count++;
		end
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
